// ===== rtl/tvc_pkg.sv =====
// Shared types and constants of the tracking velocity controller.
// No dependencies; used by tvc_ctrl, tvc_dpath and the top level.
package tvc_pkg;

   localparam int POS_W  = 16;                 // Q4.12 position and command
   localparam int DIFF_W = POS_W + 1;          // difference of two positions
   localparam int VEL_W  = 28;                 // difference times sample rate
   localparam int VERR_W = VEL_W + 1;          // velocity error
   localparam int SUM_W  = 32;                 // saturating error sum
   localparam int MUL_A_W = DIFF_W;            // shared multiplier operand a
   localparam int MUL_B_W = SUM_W;             // shared multiplier operand b
   localparam int PROD_W = 48;                 // largest product that can occur
   localparam int ACC_W  = PROD_W + 2;         // sum of four products
   localparam int FRAC_W = 12;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [2:0] REG_GAIN_POSITION  = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEGRAL  = 3'd1;
   localparam logic [2:0] REG_GAIN_VEL_ERROR = 3'd2;
   localparam logic [2:0] REG_GAIN_FEEDFWD   = 3'd3;
   localparam logic [2:0] REG_SPEED_LIMIT    = 3'd4;
   localparam logic [2:0] REG_LAND_TOL       = 3'd5;
   localparam logic [2:0] REG_ARENA_HALF     = 3'd6;
   localparam logic [2:0] REG_SAMPLE_RATE    = 3'd7;

   // Fixed-point constants in Q4.12.
   localparam logic signed [POS_W-1:0] ARENA_FLOOR = 16'sd1229;
   localparam logic signed [POS_W-1:0] ARENA_CEIL  = 16'sd8192;
   localparam logic signed [DIFF_W-1:0] CLEARANCE  = -17'sd1106;
   localparam logic signed [POS_W-1:0] FALLBACK_Z  = 16'sd3072;
   localparam logic signed [POS_W-1:0] DESCENT_Z   = -16'sd410;
   localparam logic signed [POS_W-1:0] CLIMB_Z     = 16'sd819;
   localparam logic signed [POS_W-1:0] CENTRE_Z    = 16'sd4096;

   localparam logic KIND_VELOCITY = 1'b0;
   localparam logic KIND_POSITION = 1'b1;

   // Order of the operations on the shared multiplier.
   typedef enum logic [3:0] {
      OP_VEL_TX, OP_VEL_TY, OP_VEL_VX, OP_VEL_VY,
      OP_FF_X, OP_VE_X, OP_PE_X, OP_SUM_X,
      OP_FF_Y, OP_VE_Y, OP_PE_Y, OP_SUM_Y
   } mac_op_type;

   localparam logic [3:0] MAC_LAST_STEP = 4'd12;

   typedef struct packed {
      logic signed [15:0] gain_position;
      logic signed [15:0] gain_integral;
      logic signed [15:0] gain_vel_error;
      logic signed [15:0] gain_feedfwd;
      logic [14:0]        speed_limit;
      logic [14:0]        land_tol;
      logic [14:0]        arena_half;
      logic [9:0]         sample_rate;
   } cfg_type;

   typedef struct packed {
      logic       load;        // latch the request beat
      logic       prep;        // error terms, arena test, state update
      logic       issue_en;    // drive the multiplier
      mac_op_type issue_op;
      logic       consume_en;  // use the registered product
      mac_op_type consume_op;
      logic       fin_load;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic centre;            // centre command instead of velocity command
   } status_type;

endpackage

// ===== rtl/tvc_ctrl.sv =====
// Sequencer of the tracking velocity controller: state machine and handshakes.
// Depends on tvc_pkg; drives the command struct of tvc_dpath.
module tvc_ctrl
   import tvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {S_IDLE, S_PREP, S_MAC, S_FIN} state_type;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.prep       = (state_ff == S_PREP);
      cmd.issue_en   = (state_ff == S_MAC) && (step_ff != MAC_LAST_STEP);
      cmd.issue_op   = mac_op_type'(step_ff);
      cmd.consume_en = (state_ff == S_MAC) && (step_ff != 4'd0);
      cmd.consume_op = mac_op_type'(step_ff - 4'd1);
      cmd.fin_load   = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            step_in  = 4'd0;
            state_in = status.centre ? S_FIN : S_MAC;
         end
         S_MAC: begin
            step_in = step_ff + 4'd1;
            if (step_ff == MAC_LAST_STEP) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (cmd.fin_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_PREP)
      else $error("accepted beat did not start preparation");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> step_ff <= MAC_LAST_STEP)
      else $error("multiplier step beyond last operation");

   a_mac_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && step_ff == MAC_LAST_STEP) |=> state_ff == S_FIN)
      else $error("multiply sequence did not finish");

   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result load did not raise response valid");

endmodule

// ===== rtl/tvc_dpath.sv =====
// Datapath of the tracking velocity controller: history, error terms, one
// shared multiplier with accumulator, and the result register. Uses tvc_pkg.
module tvc_dpath
   import tvc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [POS_W-1:0]  req_target_x,
   input  logic signed [POS_W-1:0]  req_target_y,
   input  logic signed [POS_W-1:0]  req_target_z,
   input  logic signed [POS_W-1:0]  req_vehicle_x,
   input  logic signed [POS_W-1:0]  req_vehicle_y,
   input  logic signed [POS_W-1:0]  req_vehicle_z,
   output logic                     rsp_command_kind,
   output logic signed [POS_W-1:0]  rsp_cmd_x,
   output logic signed [POS_W-1:0]  rsp_cmd_y,
   output logic signed [POS_W-1:0]  rsp_cmd_z,
   output logic                     rsp_aborted
);

   // Latched request.
   logic signed [POS_W-1:0] tx_ff, ty_ff, tz_ff, vx_ff, vy_ff, vz_ff;
   // Controller state kept across beats.
   logic signed [POS_W-1:0] ptx_ff, pty_ff, pvx_ff, pvy_ff;
   logic signed [VEL_W-1:0] tvx_ff, tvy_ff, vvx_ff, vvy_ff;
   logic signed [SUM_W-1:0] sumx_ff, sumy_ff, sumx_in, sumy_in;
   logic                    clear_flag_ff, abort_ff, primed_ff;
   // Per-beat working registers.
   logic signed [DIFF_W-1:0] ex_ff, ey_ff, dtx_ff, dty_ff, dvx_ff, dvy_ff;
   logic signed [VERR_W-1:0] evx_ff, evy_ff;
   logic                     centre_ff, descend_ff, climb_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [POS_W-1:0]  cmdx_ff;

   // Preparation logic.
   logic signed [POS_W-1:0]  ptx, pty, pvx, pvy;
   logic signed [DIFF_W-1:0] ex, ey, ez;
   logic signed [DIFF_W:0]   aw, tol;
   logic                     in_arena, near_x, near_y, flag_set, climb;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]  a,
      input logic signed [DIFF_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

   function automatic logic signed [POS_W-1:0] clamp(
      input logic signed [ACC_W-1:0] acc,
      input logic [14:0]             lim
   );
      logic signed [ACC_W-FRAC_W-1:0] sh;
      logic signed [ACC_W-FRAC_W-1:0] hi;
      sh = acc[ACC_W-1:FRAC_W];
      hi = (ACC_W-FRAC_W)'({1'b0, lim});
      if (sh > hi) begin
         clamp = POS_W'(hi);
      end else if (sh < -hi) begin
         clamp = POS_W'(-hi);
      end else begin
         clamp = sh[POS_W-1:0];
      end
   endfunction

   always_comb begin
      // The first beat after reset seeds the history with its own positions.
      ptx = primed_ff ? ptx_ff : tx_ff;
      pty = primed_ff ? pty_ff : ty_ff;
      pvx = primed_ff ? pvx_ff : vx_ff;
      pvy = primed_ff ? pvy_ff : vy_ff;
      ex  = DIFF_W'(tx_ff) - DIFF_W'(vx_ff);
      ey  = DIFF_W'(ty_ff) - DIFF_W'(vy_ff);
      ez  = DIFF_W'(tz_ff) - DIFF_W'(vz_ff);
      sumx_in = sat_add(sumx_ff, ex);
      sumy_in = sat_add(sumy_ff, ey);
      aw  = (DIFF_W+1)'({1'b0, cfg.arena_half});
      tol = (DIFF_W+1)'({1'b0, cfg.land_tol});
      in_arena = ((DIFF_W+1)'(vx_ff) < aw) && ((DIFF_W+1)'(vx_ff) > -aw) &&
                 ((DIFF_W+1)'(vy_ff) < aw) && ((DIFF_W+1)'(vy_ff) > -aw) &&
                 (vz_ff < ARENA_CEIL) && (vz_ff > ARENA_FLOOR);
      near_x   = ((DIFF_W+1)'(ex) < tol) && ((DIFF_W+1)'(ex) > -tol);
      near_y   = ((DIFF_W+1)'(ey) < tol) && ((DIFF_W+1)'(ey) > -tol);
      flag_set = (ez > CLEARANCE) || clear_flag_ff;
      climb    = (vz_ff < FALLBACK_Z) && flag_set;
      status.centre = abort_ff || !in_arena;
   end

   // Shared multiplier operands.
   logic signed [MUL_A_W-1:0]         mul_a;
   logic signed [MUL_B_W-1:0]         mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
   logic signed [MUL_B_W-1:0]         rate_b;

   assign rate_b = MUL_B_W'({1'b0, cfg.sample_rate});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.issue_op)
         OP_VEL_TX: begin mul_a = dtx_ff; mul_b = rate_b; end
         OP_VEL_TY: begin mul_a = dty_ff; mul_b = rate_b; end
         OP_VEL_VX: begin mul_a = dvx_ff; mul_b = rate_b; end
         OP_VEL_VY: begin mul_a = dvy_ff; mul_b = rate_b; end
         OP_FF_X: begin
            mul_a = MUL_A_W'(cfg.gain_feedfwd);   mul_b = MUL_B_W'(tvx_ff);
         end
         OP_VE_X: begin
            mul_a = MUL_A_W'(cfg.gain_vel_error); mul_b = MUL_B_W'(evx_ff);
         end
         OP_PE_X: begin
            mul_a = MUL_A_W'(cfg.gain_position);  mul_b = MUL_B_W'(ex_ff);
         end
         OP_SUM_X: begin
            mul_a = MUL_A_W'(cfg.gain_integral);  mul_b = sumx_ff;
         end
         OP_FF_Y: begin
            mul_a = MUL_A_W'(cfg.gain_feedfwd);   mul_b = MUL_B_W'(tvy_ff);
         end
         OP_VE_Y: begin
            mul_a = MUL_A_W'(cfg.gain_vel_error); mul_b = MUL_B_W'(evy_ff);
         end
         OP_PE_Y: begin
            mul_a = MUL_A_W'(cfg.gain_position);  mul_b = MUL_B_W'(ey_ff);
         end
         OP_SUM_Y: begin
            mul_a = MUL_A_W'(cfg.gain_integral);  mul_b = sumy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tx_ff <= req_target_x;
         ty_ff <= req_target_y;
         tz_ff <= req_target_z;
         vx_ff <= req_vehicle_x;
         vy_ff <= req_vehicle_y;
         vz_ff <= req_vehicle_z;
      end
      if (cmd.prep) begin
         ex_ff      <= ex;
         ey_ff      <= ey;
         evx_ff     <= VERR_W'(tvx_ff) - VERR_W'(vvx_ff);
         evy_ff     <= VERR_W'(tvy_ff) - VERR_W'(vvy_ff);
         dtx_ff     <= DIFF_W'(tx_ff) - DIFF_W'(ptx);
         dty_ff     <= DIFF_W'(ty_ff) - DIFF_W'(pty);
         dvx_ff     <= DIFF_W'(vx_ff) - DIFF_W'(pvx);
         dvy_ff     <= DIFF_W'(vy_ff) - DIFF_W'(pvy);
         centre_ff  <= status.centre;
         descend_ff <= near_x && near_y;
         climb_ff   <= climb;
      end
      if (cmd.issue_en) begin
         prod_ff <= mul_p[PROD_W-1:0];
      end
      if (cmd.consume_en) begin
         case (cmd.consume_op)
            OP_FF_X: acc_ff <= ACC_W'(prod_ff);
            OP_FF_Y: begin
               acc_ff  <= ACC_W'(prod_ff);
               cmdx_ff <= clamp(acc_ff, cfg.speed_limit);
            end
            OP_VE_X, OP_PE_X, OP_SUM_X, OP_VE_Y, OP_PE_Y, OP_SUM_Y:
               acc_ff <= acc_ff + ACC_W'(prod_ff);
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.fin_load) begin
         if (centre_ff) begin
            rsp_command_kind <= KIND_POSITION;
            rsp_cmd_x        <= '0;
            rsp_cmd_y        <= '0;
            rsp_cmd_z        <= CENTRE_Z;
            rsp_aborted      <= 1'b1;
         end else if (climb_ff) begin
            rsp_command_kind <= KIND_VELOCITY;
            rsp_cmd_x        <= '0;
            rsp_cmd_y        <= '0;
            rsp_cmd_z        <= CLIMB_Z;
            rsp_aborted      <= 1'b0;
         end else begin
            rsp_command_kind <= KIND_VELOCITY;
            rsp_cmd_x        <= cmdx_ff;
            rsp_cmd_y        <= clamp(acc_ff, cfg.speed_limit);
            rsp_cmd_z        <= descend_ff ? DESCENT_Z : '0;
            rsp_aborted      <= 1'b0;
         end
      end
   end

   // Controller state that persists between beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptx_ff <= '0; pty_ff <= '0; pvx_ff <= '0; pvy_ff <= '0;
         tvx_ff <= '0; tvy_ff <= '0; vvx_ff <= '0; vvy_ff <= '0;
         sumx_ff       <= '0;
         sumy_ff       <= '0;
         clear_flag_ff <= 1'b0;
         abort_ff      <= 1'b0;
         primed_ff     <= 1'b0;
      end else begin
         if (cmd.prep && !abort_ff) begin
            primed_ff <= 1'b1;
            sumx_ff   <= sumx_in;
            sumy_ff   <= sumy_in;
            if (!in_arena) begin
               abort_ff <= 1'b1;
            end else begin
               ptx_ff        <= tx_ff;
               pty_ff        <= ty_ff;
               pvx_ff        <= vx_ff;
               pvy_ff        <= vy_ff;
               clear_flag_ff <= climb;
            end
         end
         if (cmd.consume_en) begin
            case (cmd.consume_op)
               OP_VEL_TX: tvx_ff <= prod_ff[VEL_W-1:0];
               OP_VEL_TY: tvy_ff <= prod_ff[VEL_W-1:0];
               OP_VEL_VX: vvx_ff <= prod_ff[VEL_W-1:0];
               OP_VEL_VY: vvy_ff <= prod_ff[VEL_W-1:0];
               default:   tvx_ff <= tvx_ff;
            endcase
         end
      end
   end

endmodule

// ===== rtl/tracking_velocity_controller_core.sv =====
// Top level of the tracking velocity controller: register file and wiring.
// Depends on tvc_pkg, tvc_ctrl and tvc_dpath.
// A velocity command passes through preparation, the multiply steps and the
// result load; a centre command (abort) skips the multiply steps. One multiplier is
// shared by twelve products. A new beat is taken only once the previous command
// is in the result register, and a held response stalls that load.
// Reset is synchronous and active high; it restores register defaults and
// clears history, sums and flags.
module tracking_velocity_controller_core
   import tvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel: one beat per control tick.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [POS_W-1:0] req_target_x,
   input  logic signed [POS_W-1:0] req_target_y,
   input  logic signed [POS_W-1:0] req_target_z,
   input  logic signed [POS_W-1:0] req_vehicle_x,
   input  logic signed [POS_W-1:0] req_vehicle_y,
   input  logic signed [POS_W-1:0] req_vehicle_z,
   // Response channel: one command beat per request beat.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_command_kind,
   output logic signed [POS_W-1:0] rsp_cmd_x,
   output logic signed [POS_W-1:0] rsp_cmd_y,
   output logic signed [POS_W-1:0] rsp_cmd_z,
   output logic                    rsp_aborted,
   // Configuration port.
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // The register file. Registers sit on 32-bit word addresses, so the word
   // index is the address with its two byte bits dropped. Writes take effect
   // on the access phase; the port never inserts wait states.
   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       csr_write;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_position  <= 16'sd5734;
         cfg_ff.gain_integral  <= 16'sd0;
         cfg_ff.gain_vel_error <= 16'sd0;
         cfg_ff.gain_feedfwd   <= 16'sd4096;
         cfg_ff.speed_limit    <= 15'd1434;
         cfg_ff.land_tol       <= 15'd164;
         cfg_ff.arena_half     <= 15'd6144;
         cfg_ff.sample_rate    <= 10'd25;
      end else if (csr_write) begin
         case (reg_index)
            REG_GAIN_POSITION:  cfg_ff.gain_position  <= csr_pwdata[15:0];
            REG_GAIN_INTEGRAL:  cfg_ff.gain_integral  <= csr_pwdata[15:0];
            REG_GAIN_VEL_ERROR: cfg_ff.gain_vel_error <= csr_pwdata[15:0];
            REG_GAIN_FEEDFWD:   cfg_ff.gain_feedfwd   <= csr_pwdata[15:0];
            REG_SPEED_LIMIT:    cfg_ff.speed_limit    <= csr_pwdata[14:0];
            REG_LAND_TOL:       cfg_ff.land_tol       <= csr_pwdata[14:0];
            REG_ARENA_HALF:     cfg_ff.arena_half     <= csr_pwdata[14:0];
            REG_SAMPLE_RATE:    cfg_ff.sample_rate    <= csr_pwdata[9:0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   // Read data is the raw register contents, zero extended to the bus.
   always_comb begin
      case (reg_index)
         REG_GAIN_POSITION:  csr_prdata = CSR_DATA_W'({1'b0, cfg_ff.gain_position});
         REG_GAIN_INTEGRAL:  csr_prdata = CSR_DATA_W'({1'b0, cfg_ff.gain_integral});
         REG_GAIN_VEL_ERROR: csr_prdata = CSR_DATA_W'({1'b0, cfg_ff.gain_vel_error});
         REG_GAIN_FEEDFWD:   csr_prdata = CSR_DATA_W'({1'b0, cfg_ff.gain_feedfwd});
         REG_SPEED_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.speed_limit);
         REG_LAND_TOL:       csr_prdata = CSR_DATA_W'(cfg_ff.land_tol);
         REG_ARENA_HALF:     csr_prdata = CSR_DATA_W'(cfg_ff.arena_half);
         REG_SAMPLE_RATE:    csr_prdata = CSR_DATA_W'(cfg_ff.sample_rate);
         default:            csr_prdata = '0;
      endcase
   end

   // The sequencer steps through preparation, the twelve products on the shared
   // multiplier and the result load. The datapath reports only whether the beat
   // ends in the centre command, which skips the multiply phase.
   cmd_type    cmd;
   status_type status;

   tvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the tick history, the velocity estimates, the error
   // sums and the latched abort, plus the result register. The result
   // register lets a finished command wait while the next beat is taken.
   tvc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_z     (req_target_z),
      .req_vehicle_x    (req_vehicle_x),
      .req_vehicle_y    (req_vehicle_y),
      .req_vehicle_z    (req_vehicle_z),
      .rsp_command_kind (rsp_command_kind),
      .rsp_cmd_x        (rsp_cmd_x),
      .rsp_cmd_y        (rsp_cmd_y),
      .rsp_cmd_z        (rsp_cmd_z),
      .rsp_aborted      (rsp_aborted)
   );

endmodule
